FILE: rtl/pph_pkg.sv
`timescale 1ns / 1ps

package pph_pkg;

	// Default store geometry
	localparam int DEF_MAX_X_BINS = 64;
	localparam int DEF_MAX_Y_BINS = 64;
	localparam int DEF_COUNT_BITS = 32;

	// Fixed field widths
	localparam int POS_W     = 32;
	localparam int NBINS_W   = 7;
	localparam int INV_W     = 24;
	localparam int BIN_W     = 6;
	localparam int OUT_CNT_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	localparam int PROD_W    = POS_W + INV_W;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_MIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_MAX_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_MIN_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_MAX_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS_X    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS_Y    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_X     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_Y     = 3'd7;

	// Register reset values
	localparam logic signed [POS_W-1:0] RST_WIN_MIN = -32'sd1310720;
	localparam logic signed [POS_W-1:0] RST_WIN_MAX = 32'sd1310720;
	localparam logic [NBINS_W-1:0]      RST_BINS    = 7'd40;
	localparam logic [INV_W-1:0]        RST_INV     = 24'd65536;

endpackage

FILE: rtl/pph_ram.sv
`timescale 1ns / 1ps

module pph_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/planar_position_histogram_unit.sv
`timescale 1ns / 1ps

// A read item passes the address, read and update states. An add item checks the window and
// ends there if outside it; else it multiplies and clamps each axis before the address, read
// and update states. busy drops in the done cycle. A shared 32x24 multiplier and a shared
// 33-bit subtractor serve both axes in turn; each bin update is a read-modify-write of the
// counters. After reset all MAX_X_BINS * MAX_Y_BINS counters (4096 by default) are zeroed
// one per cycle with busy high; config writes are taken throughout. Results never stall.

module planar_position_histogram_unit #(
	parameter int MAX_X_BINS = pph_pkg::DEF_MAX_X_BINS,
	parameter int MAX_Y_BINS = pph_pkg::DEF_MAX_Y_BINS,
	parameter int COUNT_BITS = pph_pkg::DEF_COUNT_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  action,
	input  logic signed [pph_pkg::POS_W-1:0]      pos_x,
	input  logic signed [pph_pkg::POS_W-1:0]      pos_y,
	input  logic        [pph_pkg::BIN_W-1:0]      read_bin_x,
	input  logic        [pph_pkg::BIN_W-1:0]      read_bin_y,

	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [pph_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [pph_pkg::CFG_DAT_W-1:0]  cfg_data,

	output logic                                  done,
	output logic                                  counted,
	output logic        [pph_pkg::BIN_W-1:0]      bin_x,
	output logic        [pph_pkg::BIN_W-1:0]      bin_y,
	output logic        [pph_pkg::OUT_CNT_W-1:0]  bin_count
);

	localparam int DEPTH = MAX_X_BINS * MAX_Y_BINS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = (MAX_X_BINS > 1) ? $clog2(MAX_X_BINS) : 1;
	localparam int YW    = (MAX_Y_BINS > 1) ? $clog2(MAX_Y_BINS) : 1;
	localparam int IW    = (XW > YW) ? XW : YW;
	localparam int NXW   = $clog2(MAX_X_BINS + 1);
	localparam int NYW   = $clog2(MAX_Y_BINS + 1);
	localparam int NW    = (NXW > NYW) ? NXW : NYW;
	localparam int PW    = pph_pkg::POS_W;
	localparam int VW    = pph_pkg::INV_W;
	localparam int MW    = pph_pkg::PROD_W;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HI_X,
		ST_LO_X,
		ST_HI_Y,
		ST_LO_Y,
		ST_MUL_X,
		ST_CLP_X,
		ST_MUL_Y,
		ST_CLP_Y,
		ST_ADDR,
		ST_RD,
		ST_UPD
	} state_t;

	state_t state_q;

	// Configuration registers
	logic signed [PW-1:0]             win_min_x_q, win_max_x_q, win_min_y_q, win_max_y_q;
	logic [pph_pkg::NBINS_W-1:0]      bins_x_q, bins_y_q;
	logic [VW-1:0]                    inv_x_q, inv_y_q;

	// Item registers
	logic                             act_q;
	logic signed [PW-1:0]             pos_x_q, pos_y_q;
	logic [pph_pkg::BIN_W-1:0]        rbx_q, rby_q;
	logic                             oor_q;
	logic                             in_q;
	logic [PW-1:0]                    off_x_q, off_y_q;
	logic [MW-1:0]                    prod_q;
	logic [XW-1:0]                    ix_q;
	logic [YW-1:0]                    iy_q;
	logic [AW-1:0]                    addr_q;
	logic [AW-1:0]                    clr_q;

	// Result registers
	logic                             done_q;
	logic                             counted_q;
	logic [pph_pkg::BIN_W-1:0]        bin_x_q, bin_y_q;
	logic [pph_pkg::OUT_CNT_W-1:0]    bin_count_q;

	// Shared datapath
	logic signed [PW-1:0]             sub_a, sub_b;
	logic [PW:0]                      diff;
	logic                             diff_pos;
	logic [PW-1:0]                    mul_a;
	logic [VW-1:0]                    mul_b;
	logic [MW-1:0]                    prod_c;
	logic [NXW-1:0]                   nx;
	logic [NYW-1:0]                   ny;
	logic [NW-1:0]                    nsel;
	logic [VW-1:0]                    bin_raw;
	logic [IW-1:0]                    bin_clamped;

	// Memory
	logic                             ram_we;
	logic [AW-1:0]                    ram_waddr;
	logic [COUNT_BITS-1:0]            ram_wdata;
	logic [COUNT_BITS-1:0]            ram_rdata;
	logic [COUNT_BITS-1:0]            cnt_next;
	logic [63:0]                      cnt_wide;
	logic [63:0]                      rd_wide;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);

	assign done      = done_q;
	assign counted   = counted_q;
	assign bin_x     = bin_x_q;
	assign bin_y     = bin_y_q;
	assign bin_count = bin_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_min_x_q <= pph_pkg::RST_WIN_MIN;
			win_max_x_q <= pph_pkg::RST_WIN_MAX;
			win_min_y_q <= pph_pkg::RST_WIN_MIN;
			win_max_y_q <= pph_pkg::RST_WIN_MAX;
			bins_x_q    <= pph_pkg::RST_BINS;
			bins_y_q    <= pph_pkg::RST_BINS;
			inv_x_q     <= pph_pkg::RST_INV;
			inv_y_q     <= pph_pkg::RST_INV;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pph_pkg::CFG_WIN_MIN_X: win_min_x_q <= cfg_data;
				pph_pkg::CFG_WIN_MAX_X: win_max_x_q <= cfg_data;
				pph_pkg::CFG_WIN_MIN_Y: win_min_y_q <= cfg_data;
				pph_pkg::CFG_WIN_MAX_Y: win_max_y_q <= cfg_data;
				pph_pkg::CFG_BINS_X:    bins_x_q    <= cfg_data[pph_pkg::NBINS_W-1:0];
				pph_pkg::CFG_BINS_Y:    bins_y_q    <= cfg_data[pph_pkg::NBINS_W-1:0];
				pph_pkg::CFG_INV_X:     inv_x_q     <= cfg_data[VW-1:0];
				pph_pkg::CFG_INV_Y:     inv_y_q     <= cfg_data[VW-1:0];
				default: ;
			endcase
		end
	end

	// Bins in use: zero acts as one, above the store size acts as the store size
	always_comb begin
		if (bins_x_q == '0) begin
			nx = NXW'(1);
		end else if (32'(bins_x_q) > 32'(MAX_X_BINS)) begin
			nx = NXW'(MAX_X_BINS);
		end else begin
			nx = NXW'(bins_x_q);
		end
		if (bins_y_q == '0) begin
			ny = NYW'(1);
		end else if (32'(bins_y_q) > 32'(MAX_Y_BINS)) begin
			ny = NYW'(MAX_Y_BINS);
		end else begin
			ny = NYW'(bins_y_q);
		end
	end

	// Shared subtractor: window bound checks and offsets from the lower bound
	always_comb begin
		case (state_q)
			ST_HI_X: begin
				sub_a = win_max_x_q;
				sub_b = pos_x_q;
			end
			ST_LO_X: begin
				sub_a = pos_x_q;
				sub_b = win_min_x_q;
			end
			ST_HI_Y: begin
				sub_a = win_max_y_q;
				sub_b = pos_y_q;
			end
			default: begin
				sub_a = pos_y_q;
				sub_b = win_min_y_q;
			end
		endcase
	end

	assign diff     = {sub_a[PW-1], sub_a} - {sub_b[PW-1], sub_b};
	assign diff_pos = !diff[PW] && (diff != '0);

	// Shared multiplier
	assign mul_a  = (state_q == ST_MUL_X) ? off_x_q : off_y_q;
	assign mul_b  = (state_q == ST_MUL_X) ? inv_x_q : inv_y_q;
	assign prod_c = {{VW{1'b0}}, mul_a} * {{PW{1'b0}}, mul_b};

	// Shared clamp to the last bin in use
	assign nsel    = (state_q == ST_CLP_X) ? NW'(nx) : NW'(ny);
	assign bin_raw = prod_q[MW-1:PW];

	always_comb begin
		if (32'(bin_raw) >= 32'(nsel)) begin
			bin_clamped = IW'(nsel - NW'(1));
		end else begin
			bin_clamped = IW'(bin_raw);
		end
	end

	// Saturating increment
	assign cnt_next  = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
	assign cnt_wide  = 64'(cnt_next);
	assign rd_wide   = 64'(ram_rdata);

	assign ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_UPD) && !act_q);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : addr_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : cnt_next;

	pph_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (start) begin
						act_q   <= action;
						pos_x_q <= pos_x;
						pos_y_q <= pos_y;
						rbx_q   <= read_bin_x;
						rby_q   <= read_bin_y;
						ix_q    <= XW'(read_bin_x);
						iy_q    <= YW'(read_bin_y);
						oor_q   <= (32'(read_bin_x) >= 32'(MAX_X_BINS)) ||
						           (32'(read_bin_y) >= 32'(MAX_Y_BINS));
						state_q <= action ? ST_ADDR : ST_HI_X;
					end
				end
				ST_HI_X: begin
					in_q    <= diff_pos;
					state_q <= ST_LO_X;
				end
				ST_LO_X: begin
					in_q    <= in_q && diff_pos;
					off_x_q <= diff[PW-1:0];
					state_q <= ST_HI_Y;
				end
				ST_HI_Y: begin
					in_q    <= in_q && diff_pos;
					state_q <= ST_LO_Y;
				end
				ST_LO_Y: begin
					off_y_q <= diff[PW-1:0];
					if (in_q && diff_pos) begin
						state_q <= ST_MUL_X;
					end else begin
						// outside the window: report zeros, store nothing
						done_q      <= 1'b1;
						counted_q   <= 1'b0;
						bin_x_q     <= '0;
						bin_y_q     <= '0;
						bin_count_q <= '0;
						state_q     <= ST_IDLE;
					end
				end
				ST_MUL_X: begin
					prod_q  <= prod_c;
					state_q <= ST_CLP_X;
				end
				ST_CLP_X: begin
					ix_q    <= XW'(bin_clamped);
					state_q <= ST_MUL_Y;
				end
				ST_MUL_Y: begin
					prod_q  <= prod_c;
					state_q <= ST_CLP_Y;
				end
				ST_CLP_Y: begin
					iy_q    <= YW'(bin_clamped);
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					addr_q  <= AW'(AW'(ix_q) * AW'(MAX_Y_BINS)) + AW'(iy_q);
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					done_q <= 1'b1;
					if (act_q) begin
						counted_q   <= 1'b0;
						bin_x_q     <= rbx_q;
						bin_y_q     <= rby_q;
						bin_count_q <= oor_q ? '0 : rd_wide[pph_pkg::OUT_CNT_W-1:0];
					end else begin
						counted_q   <= 1'b1;
						bin_x_q     <= pph_pkg::BIN_W'(ix_q);
						bin_y_q     <= pph_pkg::BIN_W'(iy_q);
						bin_count_q <= cnt_wide[pph_pkg::OUT_CNT_W-1:0];
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
